/* src/tlnf_pkg.sv */
package tlnf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int BCD_W         = 4 * NUMBER_DIGITS;
  localparam int DIG_IDX_W     = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;
  localparam int CFG_IDX_W     = 3;

  localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_QUESTION = 8'd63;
  localparam logic [7:0] CH_UPPER_I  = 8'd73;
  localparam logic [7:0] CH_CARET    = 8'd94;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CARET_OFS   = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_NUMBER_ALL       = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_NONPRINTING = 3'd3,
    REG_SHOW_ENDS        = 3'd4,
    REG_SHOW_TABS        = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_DIGIT,
    PH_TAB,
    PH_PRE,
    PH_CHAR
  } phase_e;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_nonprinting;
    logic show_ends;
    logic show_tabs;
  } cfg_t;

  // one queued command: optional number, optional prefix byte, final byte
  typedef struct packed {
    logic             num_en;
    logic [BCD_W-1:0] bcd;
    logic             pre_en;
    logic [7:0]       pre_byte;
    logic [7:0]       chr;
  } cmd_t;

  function automatic logic bcd_all_nines(logic [BCD_W-1:0] v);
    logic r;
    r = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (v[i*4 +: 4] != 4'd9) r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [BCD_W-1:0] bcd_increment(logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             carry;
    r     = v;
    carry = 1'b1;
    if (!bcd_all_nines(v)) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        if (carry) begin
          if (v[i*4 +: 4] == 4'd9) begin
            r[i*4 +: 4] = 4'd0;
          end else begin
            r[i*4 +: 4] = v[i*4 +: 4] + 4'd1;
            carry       = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  // bit k set when digit k prints as a space (leading zero, not the lowest)
  function automatic logic [NUMBER_DIGITS-1:0] lead_blanks(logic [BCD_W-1:0] v);
    logic [NUMBER_DIGITS-1:0] r;
    logic                     run;
    r   = '0;
    run = 1'b1;
    for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
      run  = run & (v[k*4 +: 4] == 4'd0);
      r[k] = run & (k != 0);
    end
    return r;
  endfunction

endpackage

/* src/tlnf_front.sv */
module tlnf_front
  import tlnf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       new_file_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic             prev_nl_q, prev_nl_d;
  logic [1:0]       blank_q, blank_d;

  logic             accept;
  logic             is_nl;
  logic             eff_prev;
  logic [1:0]       eff_blank;
  logic [BCD_W-1:0] eff_bcd;
  logic             squeeze_hit;
  logic [1:0]       run_next;
  logic             drop;
  logic             emit_number;
  logic             ctrl_byte;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_nl      = (data_byte_i == CH_NEWLINE);

  // a new file restarts the stream state before the byte is looked at
  assign eff_prev  = new_file_i ? 1'b1 : prev_nl_q;
  assign eff_blank = new_file_i ? 2'd0 : blank_q;
  assign eff_bcd   = new_file_i ? BCD_ONE : bcd_q;

  assign squeeze_hit = cfg_i.squeeze_blank && is_nl && eff_prev;
  assign run_next    = squeeze_hit ? ((eff_blank == 2'd2) ? 2'd2 : eff_blank + 2'd1) : 2'd0;
  assign drop        = squeeze_hit && (run_next == 2'd2);

  assign emit_number = cfg_i.number_nonblank ? (eff_prev && !is_nl)
                                             : (cfg_i.number_all && eff_prev);

  assign ctrl_byte = (data_byte_i < CH_TAB) ||
                     ((data_byte_i > CH_NEWLINE) && (data_byte_i < CH_SPACE)) ||
                     (data_byte_i == CH_DEL);

  always_comb begin
    q_cmd_o.num_en   = emit_number;
    q_cmd_o.bcd      = eff_bcd;
    q_cmd_o.pre_en   = 1'b0;
    q_cmd_o.pre_byte = CH_CARET;
    q_cmd_o.chr      = data_byte_i;
    if (cfg_i.show_nonprinting && ctrl_byte) begin
      q_cmd_o.pre_en = 1'b1;
      q_cmd_o.chr    = (data_byte_i == CH_DEL) ? CH_QUESTION : data_byte_i + CARET_OFS;
    end else if (cfg_i.show_ends && is_nl) begin
      q_cmd_o.pre_en   = 1'b1;
      q_cmd_o.pre_byte = CH_DOLLAR;
    end else if (cfg_i.show_tabs && (data_byte_i == CH_TAB)) begin
      q_cmd_o.pre_en = 1'b1;
      q_cmd_o.chr    = CH_UPPER_I;
    end
  end

  assign q_push_o = accept && !drop;

  always_comb begin
    bcd_d     = bcd_q;
    prev_nl_d = prev_nl_q;
    blank_d   = blank_q;
    if (accept) begin
      blank_d = run_next;
      if (drop) begin
        bcd_d     = eff_bcd;
        prev_nl_d = eff_prev;
      end else begin
        bcd_d     = emit_number ? bcd_increment(eff_bcd) : eff_bcd;
        prev_nl_d = is_nl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q     <= BCD_ONE;
      prev_nl_q <= 1'b1;
      blank_q   <= 2'd0;
    end else begin
      bcd_q     <= bcd_d;
      prev_nl_q <= prev_nl_d;
      blank_q   <= blank_d;
    end
  end

endmodule

/* src/tlnf_queue.sv */
module tlnf_queue
  import tlnf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QCNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* src/tlnf_back.sv */
module tlnf_back
  import tlnf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  localparam logic [DIG_IDX_W-1:0] LAST_DIG = DIG_IDX_W'(NUMBER_DIGITS - 1);

  phase_e               ph_q, ph_d, cur_ph;
  logic [DIG_IDX_W-1:0] dig_q, dig_d, cur_dig;
  logic                 started_q, started_d;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 last_q;
  logic                 advance;
  logic [DIG_IDX_W-1:0] pos;
  logic [3:0]           digit;
  logic [NUMBER_DIGITS-1:0] blanks;
  logic [7:0]           byte_c;

  assign advance = head_valid_i && (!out_valid_q || out_ready_i);

  // the first phase of a command comes from its flags
  always_comb begin
    cur_ph  = ph_q;
    cur_dig = dig_q;
    if (!started_q) begin
      cur_dig = '0;
      if (head_cmd_i.num_en) cur_ph = PH_DIGIT;
      else if (head_cmd_i.pre_en) cur_ph = PH_PRE;
      else cur_ph = PH_CHAR;
    end
  end

  // next state
  always_comb begin
    ph_d      = ph_q;
    dig_d     = dig_q;
    started_d = started_q;
    pop_o     = 1'b0;
    if (advance) begin
      unique case (cur_ph)
        PH_DIGIT: begin
          started_d = 1'b1;
          if (cur_dig == LAST_DIG) begin
            ph_d  = PH_TAB;
            dig_d = '0;
          end else begin
            ph_d  = PH_DIGIT;
            dig_d = cur_dig + DIG_IDX_W'(1);
          end
        end
        PH_TAB: begin
          started_d = 1'b1;
          ph_d      = head_cmd_i.pre_en ? PH_PRE : PH_CHAR;
        end
        PH_PRE: begin
          started_d = 1'b1;
          ph_d      = PH_CHAR;
        end
        PH_CHAR: begin
          started_d = 1'b0;
          dig_d     = '0;
          pop_o     = 1'b1;
        end
        default: begin
          started_d = 1'b0;
        end
      endcase
    end
  end

  // digits go out most significant first
  assign pos    = LAST_DIG - cur_dig;
  assign digit  = head_cmd_i.bcd[pos*4 +: 4];
  assign blanks = lead_blanks(head_cmd_i.bcd);

  // outputs
  always_comb begin
    unique case (cur_ph)
      PH_DIGIT: byte_c = blanks[pos] ? CH_SPACE : CH_ZERO + {4'd0, digit};
      PH_TAB:   byte_c = CH_TAB;
      PH_PRE:   byte_c = head_cmd_i.pre_byte;
      PH_CHAR:  byte_c = head_cmd_i.chr;
      default:  byte_c = head_cmd_i.chr;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_CHAR;
      dig_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ph_q      <= ph_d;
      dig_q     <= dig_d;
      started_q <= started_d;
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_c;
      last_q     <= (cur_ph == PH_CHAR);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;

endmodule

/* src/text_line_number_filter_core.sv */
// the first output byte passes through the command queue and then the output register
// throughput: one input byte per cycle when each byte gives one output byte and the
// receiver is ready; a byte gives up to NUMBER_DIGITS+3 output bytes, one per cycle from
// the back end while out_ready_i is high, and the two-entry command queue stalls the input while those drain
// reset (async, active low): options cleared, line counter 1, previous byte newline
module text_line_number_filter_core
  import tlnf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 new_file_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_run_o
);

  cfg_t cfg_q, cfg_d;
  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUMBER_NONBLANK:  cfg_d.number_nonblank  = cfg_wdata_i;
        REG_NUMBER_ALL:       cfg_d.number_all       = cfg_wdata_i;
        REG_SQUEEZE_BLANK:    cfg_d.squeeze_blank    = cfg_wdata_i;
        REG_SHOW_NONPRINTING: cfg_d.show_nonprinting = cfg_wdata_i;
        REG_SHOW_ENDS:        cfg_d.show_ends        = cfg_wdata_i;
        REG_SHOW_TABS:        cfg_d.show_tabs        = cfg_wdata_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tlnf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .new_file_i  (new_file_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd)
  );

  tlnf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (q_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  tlnf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_cmd_i    (head_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* sim/text_line_number_filter_core_tb.sv */
module text_line_number_filter_core_tb;
  import tlnf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] chr;
    logic       nf;
  } text_item_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } out_char_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic                 cfg_wdata_i = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i = '0;
  logic                 new_file_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           out_byte_o;
  logic                 last_of_run_o;

  text_line_number_filter_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .new_file_i   (new_file_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  // predictor state
  cfg_t             opts = '0;
  logic [BCD_W-1:0] line_bcd = BCD_ONE;
  logic             prev_nl = 1'b1;
  logic [1:0]       blank_run = 2'd0;

  text_item_t text_q[$];
  out_char_t  cat_out_q[$];
  text_item_t next_item;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ready = 1'b0;

  int errors = 0;
  int bytes_in = 0;
  int bytes_out = 0;
  int squeezed = 0;
  int settings = 0;
  int cycle_cnt = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [BCD_W-1:0] next_line_number(input logic [BCD_W-1:0] v);
    longint unsigned val;
    longint unsigned top;
    logic [BCD_W-1:0] r;
    val = 0;
    top = 0;
    for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
      val = val * 10 + v[k*4 +: 4];
      top = top * 10 + 9;
    end
    // holds at all nines
    if (val < top) val++;
    r = '0;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      r[k*4 +: 4] = 4'(val % 10);
      val = val / 10;
    end
    return r;
  endfunction

  task automatic cat_transform(input logic [7:0] b, input logic nf);
    logic [7:0] ch;
    logic       is_nl;
    logic       emit_num;
    logic       lead;
    logic [3:0] d;
    logic [7:0] run[$];
    out_char_t  oc;
    ch = b;
    is_nl = (b == CH_NEWLINE);
    if (nf) begin
      line_bcd = BCD_ONE;
      prev_nl = 1'b1;
      blank_run = 2'd0;
    end
    if (opts.squeeze_blank && is_nl && prev_nl) begin
      if (blank_run < 2'd2) blank_run++;
      if (blank_run > 2'd1) begin
        squeezed++;
        return;
      end
    end else begin
      blank_run = 2'd0;
    end
    if (opts.number_nonblank) emit_num = prev_nl && !is_nl;
    else emit_num = opts.number_all && prev_nl;
    if (emit_num) begin
      lead = 1'b1;
      for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
        d = line_bcd[k*4 +: 4];
        if (d != 4'd0 || k == 0) lead = 1'b0;
        run.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, d});
      end
      run.push_back(CH_TAB);
      line_bcd = next_line_number(line_bcd);
    end
    if (opts.show_nonprinting &&
        (ch < CH_TAB || (ch > CH_NEWLINE && ch < CH_SPACE) || ch == CH_DEL)) begin
      run.push_back(CH_CARET);
      ch = (ch == CH_DEL) ? CH_QUESTION : ch + CARET_OFS;
    end
    if (opts.show_ends && is_nl) run.push_back(CH_DOLLAR);
    if (opts.show_tabs && ch == CH_TAB) begin
      run.push_back(CH_CARET);
      ch = CH_UPPER_I;
    end
    run.push_back(ch);
    prev_nl = is_nl;
    foreach (run[i]) begin
      oc.chr = run[i];
      oc.last = (i == run.size() - 1);
      cat_out_q.push_back(oc);
    end
  endtask

  // input side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cat_transform(data_byte_i, new_file_i);
        bytes_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = text_q.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= next_item.chr;
          new_file_i <= next_item.nf;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    out_char_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        bytes_out++;
        if (cat_out_q.size() == 0) begin
          $display("%0t: unexpected output byte, expected none, got %h last %b",
                   $time, out_byte_o, last_of_run_o);
          errors++;
        end else begin
          want = cat_out_q.pop_front();
          if (out_byte_o !== want.chr) begin
            $display("%0t: out_byte expected %h, got %h", $time, want.chr, out_byte_o);
            errors++;
          end
          if (last_of_run_o !== want.last) begin
            $display("%0t: last_of_run expected %b, got %b", $time, want.last,
                     last_of_run_o);
            errors++;
          end
        end
      end
      out_ready_i <= !hold_ready && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_ready <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_ready <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d bytes still expected", $time, cat_out_q.size());
      $display("text_line_number_filter_core_tb NOT OK");
      $finish;
    end
  end

  function automatic void push_text(input logic [7:0] b, input logic nf);
    text_item_t t;
    t.chr = b;
    t.nf = nf;
    text_q.push_back(t);
  endfunction

  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(99);
    if (k < 70) return 8'($urandom_range(32, 126));
    if (k < 78) return CH_TAB;
    if (k < 90) return 8'($urandom_range(0, 31));
    if (k < 94) return CH_DEL;
    return 8'($urandom_range(128, 255));
  endfunction

  // mostly well-formed lines, some blank runs, a little raw noise
  task automatic gen_text(input int n_items);
    int start;
    int mode;
    int len;
    start = text_q.size();
    while (text_q.size() - start < n_items) begin
      mode = $urandom_range(99);
      if (mode < 80) begin
        len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
          push_text(rand_char(), k == 0 && $urandom_range(19) == 0);
        push_text(CH_NEWLINE, len == 0 && $urandom_range(9) == 0);
      end else if (mode < 93) begin
        repeat ($urandom_range(2, 4)) push_text(CH_NEWLINE, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4))
          push_text(8'($urandom_range(0, 255)), $urandom_range(3) == 0);
      end
    end
  endtask

  task automatic set_options(input cfg_t c);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_NUMBER_NONBLANK;
    cfg_wdata_i <= c.number_nonblank;
    @(posedge clk_i);
    cfg_idx_i <= REG_NUMBER_ALL;
    cfg_wdata_i <= c.number_all;
    @(posedge clk_i);
    cfg_idx_i <= REG_SQUEEZE_BLANK;
    cfg_wdata_i <= c.squeeze_blank;
    @(posedge clk_i);
    cfg_idx_i <= REG_SHOW_NONPRINTING;
    cfg_wdata_i <= c.show_nonprinting;
    @(posedge clk_i);
    cfg_idx_i <= REG_SHOW_ENDS;
    cfg_wdata_i <= c.show_ends;
    @(posedge clk_i);
    cfg_idx_i <= REG_SHOW_TABS;
    cfg_wdata_i <= c.show_tabs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    opts = c;
    settings++;
  endtask

  task automatic wait_idle();
    while (text_q.size() != 0 || in_valid_i || cat_out_q.size() != 0) @(posedge clk_i);
    // a dropped blank line gives no output, so let the pipeline empty too
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_pace(input int send_pct, input int recv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  initial begin
    cfg_t c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // number every line, squeeze, all the show options
    c = '0;
    c.number_all = 1'b1;
    c.squeeze_blank = 1'b1;
    c.show_nonprinting = 1'b1;
    c.show_ends = 1'b1;
    c.show_tabs = 1'b1;
    set_options(c);
    @(negedge clk_i);
    push_text("A", 1'b1);
    push_text(8'h00, 1'b0);
    push_text(8'h08, 1'b0);
    push_text(8'h0B, 1'b0);
    push_text(8'h1F, 1'b0);
    push_text(CH_DEL, 1'b0);
    push_text(CH_TAB, 1'b0);
    push_text(8'h80, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(CH_SPACE, 1'b0);
    push_text(CH_NEWLINE, 1'b0);
    push_text(CH_NEWLINE, 1'b0);
    push_text(CH_NEWLINE, 1'b0);
    push_text(CH_NEWLINE, 1'b0);
    push_text("z", 1'b0);
    push_text(CH_NEWLINE, 1'b1);
    wait_idle();

    // everything on: non-blank numbering has to win
    set_options('1);
    @(negedge clk_i);
    push_text(CH_NEWLINE, 1'b1);
    push_text("b", 1'b0);
    push_text(CH_NEWLINE, 1'b0);
    push_text(CH_NEWLINE, 1'b0);
    push_text("c", 1'b0);
    push_text(8'h7E, 1'b0);
    push_text(CH_NEWLINE, 1'b0);
    wait_idle();

    set_options('0);
    set_pace(0, 0);
    @(negedge clk_i);
    gen_text(35);
    wait_idle();

    set_options('1);
    set_pace(47, 0);
    @(negedge clk_i);
    gen_text(35);
    wait_idle();

    c = '0;
    c.number_all = 1'b1;
    c.squeeze_blank = 1'b1;
    c.show_ends = 1'b1;
    set_options(c);
    set_pace(0, 47);
    @(negedge clk_i);
    gen_text(35);
    wait_idle();

    c = '0;
    c.number_nonblank = 1'b1;
    c.show_nonprinting = 1'b1;
    c.show_tabs = 1'b1;
    set_options(c);
    set_pace(17, 17);
    @(negedge clk_i);
    gen_text(35);
    wait_idle();

    // random options, sender flat out while the receiver holds off
    c = cfg_t'(6'($urandom_range(0, 63)));
    c.number_all = 1'b1;
    set_options(c);
    set_pace(0, 0);
    @(negedge clk_i);
    gen_text(40);
    hold_req = 1'b1;
    wait_idle();

    if (cat_out_q.size() != 0) begin
      $display("%0t: %0d output bytes never arrived", $time, cat_out_q.size());
      errors++;
    end
    $display("run covered %0d input transfers (%0d blank lines squeezed) and %0d output",
             bytes_in, squeezed, bytes_out);
    $display("transfers over %0d option settings, %0d mismatches", settings, errors);
    if (errors == 0) begin
      $display("text_line_number_filter_core_tb OK");
    end else begin
      $display("text_line_number_filter_core_tb NOT OK");
    end
    $finish;
  end

endmodule
